@@ hdl/srtf_pkg.sv @@
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Field widths, request codes, the candidate word passed along the cell chain
// and the control state type shared by the scheduler modules.
// ----------------------------------------------------------------------------
package srtf_pkg;

    // Field widths of the request and result words.
    localparam int SLOT_W  = 4;
    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int BURST_W = 16;

    // Default table depth.
    localparam int DEF_MAX_TASKS = 16;

    // Saturating pending count carried along the chain: 0, 1 or "two or more".
    localparam int          PEND_W   = 2;
    localparam logic [1:0]  PEND_MAX = 2'd2;

    // Request type codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Best task seen so far, handed from cell to cell.
    typedef struct packed {
        logic               found;
        logic [BURST_W-1:0] rem;
        logic [TIME_W-1:0]  arr;
        logic [ID_W-1:0]    id;
        logic [SLOT_W-1:0]  slot;
        logic [PEND_W-1:0]  pend;
    } t_cand;

    // Slot load command broadcast to all cells.
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  arr;
        logic [BURST_W-1:0] burst;
    } t_load;

    // Run update broadcast to all cells at the end of a tick.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
    } t_upd;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD
    } t_state;

endpackage

@@ hdl/srtf_req_if.sv @@
// ----------------------------------------------------------------------------
// SRTF request channel
// Valid/ready channel carrying one request word: a slot load or a time tick.
// ----------------------------------------------------------------------------
interface srtf_req_if import srtf_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    task_id;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;

    modport source (output valid, output req_type, output slot, output task_id,
                    output arrival, output burst, input ready);
    modport sink   (input valid, input req_type, input slot, input task_id,
                    input arrival, input burst, output ready);

endinterface

@@ hdl/srtf_res_if.sv @@
// ----------------------------------------------------------------------------
// SRTF result channel
// Valid/ready channel carrying one result word per tick.
// ----------------------------------------------------------------------------
interface srtf_res_if import srtf_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  tick_time;
    logic               idle;
    logic [SLOT_W-1:0]  run_slot;
    logic [ID_W-1:0]    run_id;
    logic [BURST_W-1:0] remaining_after;
    logic               finished;
    logic               all_done;

    modport source (output valid, output tick_time, output idle, output run_slot,
                    output run_id, output remaining_after, output finished,
                    output all_done, input ready);
    modport sink   (input valid, input tick_time, input idle, input run_slot,
                    input run_id, input remaining_after, input finished,
                    input all_done, output ready);

endinterface

@@ hdl/srtf_preemptive_scheduler.sv @@
// ----------------------------------------------------------------------------
// SRTF preemptive scheduler
// Shortest-remaining-time-first task table built as a chain of slot cells.
//
// Usage: requests arrive on i_req (valid/ready). A load word (req_type 0)
// writes one table slot and gives no result; a load to a slot beyond the
// table is dropped. A tick word (req_type 1) starts a scan in which the
// best candidate moves one cell down the chain per cycle until it has
// passed all MAX_TASKS cells and the pick is known. The update state then
// commits the run and writes the result word to the output register on
// o_res. No new word is taken until the tick is through; one tick is
// handled at a time.
// The output register lets a load or the next tick be taken while a result
// waits; if the receiver stalls, a finished scan holds in its commit cycle
// until the register frees. Reset empties the table, clears the time
// counter and drops any pending result.
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler import srtf_pkg::*; #(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srtf_req_if.sink   i_req,
    srtf_res_if.source o_res
);

    localparam int CNT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [TIME_W-1:0]  r_now;

    logic               r_out_valid;
    logic [TIME_W-1:0]  r_out_time;
    logic               r_out_idle;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [ID_W-1:0]    r_out_id;
    logic [BURST_W-1:0] r_out_rem;
    logic               r_out_fin;
    logic               r_out_all;

    t_cand              w_chain [MAX_TASKS+1];
    t_cand              pick;
    t_load              load;
    t_upd               upd;
    logic               in_ready;
    logic               accept;
    logic               scan_last;
    logic               commit;
    logic               fin;

    assign accept    = i_req.valid && in_ready;
    assign scan_last = (r_cnt == CNT_W'(MAX_TASKS - 1));
    assign pick      = w_chain[MAX_TASKS];
    assign fin       = pick.found && (pick.rem == BURST_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_req.req_type == REQ_TICK)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        in_ready = 1'b0;
        commit   = 1'b0;
        case (r_state)
            ST_IDLE: in_ready = 1'b1;
            ST_SCAN: ;
            ST_UPD:  commit = !r_out_valid || o_res.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_now   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (commit) begin
                r_now <= r_now + TIME_W'(1);
            end
        end
    end

    // Load and run broadcasts to the cells.
    always_comb begin
        load.en    = accept && (i_req.req_type == REQ_LOAD);
        load.slot  = i_req.slot;
        load.id    = i_req.task_id;
        load.arr   = i_req.arrival;
        load.burst = i_req.burst;
        upd.en     = commit && pick.found;
        upd.slot   = pick.slot;
    end

    // Cell chain; the head sees no candidate and no pending tasks.
    assign w_chain[0] = '0;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        srtf_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (load),
            .i_upd   (upd),
            .i_now   (r_now),
            .i_cand  (w_chain[g]),
            .o_cand  (w_chain[g+1])
        );
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_time <= r_now;
            r_out_idle <= !pick.found;
            r_out_slot <= pick.found ? pick.slot : '0;
            r_out_id   <= pick.found ? pick.id : '0;
            r_out_rem  <= pick.found ? (pick.rem - BURST_W'(1)) : '0;
            r_out_fin  <= fin;
            // All done once no other task is pending and the run task, if any, finished.
            r_out_all  <= (pick.pend == '0) || ((pick.pend == PEND_W'(1)) && fin);
        end
    end

    assign i_req.ready           = in_ready;
    assign o_res.valid           = r_out_valid;
    assign o_res.tick_time       = r_out_time;
    assign o_res.idle            = r_out_idle;
    assign o_res.run_slot        = r_out_slot;
    assign o_res.run_id          = r_out_id;
    assign o_res.remaining_after = r_out_rem;
    assign o_res.finished        = r_out_fin;
    assign o_res.all_done        = r_out_all;

endmodule

@@ hdl/srtf_cell.sv @@
// ----------------------------------------------------------------------------
// SRTF task cell
// Holds one table slot. Each cycle it compares its task against the best
// candidate from the previous cell and registers the winner for the next one.
// ----------------------------------------------------------------------------
module srtf_cell import srtf_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_load               i_load,
    input  t_upd                i_upd,
    input  logic [TIME_W-1:0]   i_now,
    input  t_cand               i_cand,
    output t_cand               o_cand
);

    logic               r_valid;
    logic               r_done;
    logic [ID_W-1:0]    r_id;
    logic [TIME_W-1:0]  r_arr;
    logic [BURST_W-1:0] r_rem;
    t_cand              r_cand;
    t_cand              n_cand;

    logic load_hit;
    logic upd_hit;
    logic pending;
    logic eligible;
    logic wins;

    // Slot address decode; cells beyond the slot field range are never hit.
    assign load_hit = i_load.en && (32'(i_load.slot) == 32'(IDX));
    assign upd_hit  = i_upd.en && (32'(i_upd.slot) == 32'(IDX));

    // Task state: loads overwrite the slot, a run takes one tick off it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else if (load_hit) begin
            r_valid <= 1'b1;
            r_done  <= (i_load.burst == '0);
        end else if (upd_hit && (r_rem == BURST_W'(1))) begin
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_hit) begin
            r_id  <= i_load.id;
            r_arr <= i_load.arr;
            r_rem <= i_load.burst;
        end else if (upd_hit) begin
            r_rem <= r_rem - BURST_W'(1);
        end
    end

    // Compare against the incoming candidate; on a full tie the earlier slot keeps it.
    assign pending  = r_valid && !r_done;
    assign eligible = pending && (r_arr <= i_now);

    always_comb begin
        if (!i_cand.found) begin
            wins = 1'b1;
        end else if (r_rem != i_cand.rem) begin
            wins = (r_rem < i_cand.rem);
        end else if (r_arr != i_cand.arr) begin
            wins = (r_arr < i_cand.arr);
        end else begin
            wins = (r_id < i_cand.id);
        end
    end

    always_comb begin
        n_cand = i_cand;
        if (eligible && wins) begin
            n_cand.found = 1'b1;
            n_cand.rem   = r_rem;
            n_cand.arr   = r_arr;
            n_cand.id    = r_id;
            n_cand.slot  = SLOT_W'(IDX);
        end
        if (i_cand.pend == PEND_MAX) begin
            n_cand.pend = PEND_MAX;
        end else begin
            n_cand.pend = i_cand.pend + PEND_W'(pending);
        end
    end

    // Hand the winner on to the next cell.
    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end

    assign o_cand = r_cand;

endmodule
